// ===== rtl/core/lcdspd_pkg.sv =====
`timescale 1ns / 1ps

package lcdspd_pkg;

  localparam int FRAME_BYTES  = 15;
  localparam int KEPT_NIBBLES = 14;
  localparam int COUNT_W      = 4;

  // Start byte: upper nibble all ones.
  localparam logic [3:0] START_NIBBLE = 4'hf;

  localparam logic [3:0] DIGIT_UNKNOWN = 4'd15;
  // Bit 4 of a segment byte is the sign or decimal point and takes no part in the match.
  localparam logic [7:0] SEG_MASK = 8'hef;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'heb, 8'h0a, 8'had, 8'h8f, 8'h4e, 8'hc7, 8'he7, 8'h8a, 8'hef, 8'hcf
  };

  localparam logic [3:0] MODE_NONE        = 4'd0;
  localparam logic [3:0] MODE_DIODE       = 4'd1;
  localparam logic [3:0] MODE_AC          = 4'd2;
  localparam logic [3:0] MODE_DC          = 4'd3;
  localparam logic [3:0] MODE_CAPACITANCE = 4'd4;
  localparam logic [3:0] MODE_RESISTANCE  = 4'd5;
  localparam logic [3:0] MODE_FREQUENCY   = 4'd6;
  localparam logic [3:0] MODE_PERCENT     = 4'd7;
  localparam logic [3:0] MODE_TEMPERATURE = 4'd8;

  localparam logic [3:0] UNIT_UNKNOWN    = 4'd0;
  localparam logic [3:0] UNIT_FARAD      = 4'd1;
  localparam logic [3:0] UNIT_OHM        = 4'd2;
  localparam logic [3:0] UNIT_AMP        = 4'd3;
  localparam logic [3:0] UNIT_HERTZ      = 4'd4;
  localparam logic [3:0] UNIT_VOLT       = 4'd5;
  localparam logic [3:0] UNIT_PERCENT    = 4'd6;
  localparam logic [3:0] UNIT_CELSIUS    = 4'd7;
  localparam logic [3:0] UNIT_FAHRENHEIT = 4'd8;

  localparam logic [2:0] PREFIX_NONE  = 3'd0;
  localparam logic [2:0] PREFIX_NANO  = 3'd1;
  localparam logic [2:0] PREFIX_MICRO = 3'd2;
  localparam logic [2:0] PREFIX_MILLI = 3'd3;
  localparam logic [2:0] PREFIX_KILO  = 3'd4;
  localparam logic [2:0] PREFIX_MEGA  = 3'd5;

  typedef logic [3:0] nibble_t;
  typedef nibble_t frame_t [KEPT_NIBBLES];

  typedef struct packed {
    logic       overload;
    logic       negative;
    logic [3:0] digit_first;
    logic [3:0] digit_second;
    logic [3:0] digit_third;
    logic [3:0] digit_fourth;
    logic [1:0] point_after;
    logic [3:0] special_mode;
    logic [3:0] unit_code;
    logic [2:0] prefix_code;
  } reading_t;

  // Ten parallel compares against the segment table.
  function automatic logic [3:0] match_digit(input logic [7:0] pattern);
    logic [7:0] masked;
    logic [3:0] digit;
    masked = pattern & SEG_MASK;
    digit  = DIGIT_UNKNOWN;
    for (int k = 9; k >= 0; k--) begin
      if (masked == SEG_TABLE[k]) begin
        digit = 4'(k);
      end
    end
    return digit;
  endfunction

  function automatic reading_t decode_frame(input frame_t n);
    reading_t   r;
    logic [3:0] dig [4];
    for (int i = 0; i < 4; i++) begin
      dig[i] = match_digit({n[1 + 2 * i], n[2 + 2 * i]});
    end

    r.overload = ((n[3] & 4'he) == 4'he) && (n[4] == 4'hb) &&
                 ((n[5] & 4'he) == 4'h6) && (n[6] == 4'h1);
    r.negative     = r.overload ? 1'b0 : n[1][0];
    r.digit_first  = r.overload ? 4'd0 : dig[0];
    r.digit_second = r.overload ? 4'd0 : dig[1];
    r.digit_third  = r.overload ? 4'd0 : dig[2];
    r.digit_fourth = r.overload ? 4'd0 : dig[3];

    if (n[3][0]) begin
      r.point_after = 2'd1;
    end else if (n[5][0]) begin
      r.point_after = 2'd2;
    end else if (n[7][0]) begin
      r.point_after = 2'd3;
    end else begin
      r.point_after = 2'd0;
    end

    // DC beats AC, AC beats diode.
    if (n[0][1]) begin
      r.special_mode = MODE_DC;
    end else if (n[0][0]) begin
      r.special_mode = MODE_AC;
    end else if (n[9][3]) begin
      r.special_mode = MODE_DIODE;
    end else begin
      r.special_mode = MODE_NONE;
    end

    // Amps and volts keep the mode found above; the other units replace it.
    r.unit_code = UNIT_UNKNOWN;
    if (n[11][0]) begin
      r.unit_code = UNIT_FARAD;      r.special_mode = MODE_CAPACITANCE;
    end else if (n[11][1]) begin
      r.unit_code = UNIT_OHM;        r.special_mode = MODE_RESISTANCE;
    end else if (n[12][3]) begin
      r.unit_code = UNIT_AMP;
    end else if (n[12][2]) begin
      r.unit_code = UNIT_HERTZ;      r.special_mode = MODE_FREQUENCY;
    end else if (n[12][1]) begin
      r.unit_code = UNIT_VOLT;
    end else if (n[10][1]) begin
      r.unit_code = UNIT_PERCENT;    r.special_mode = MODE_PERCENT;
    end else if (n[13][1]) begin
      r.unit_code = UNIT_CELSIUS;    r.special_mode = MODE_TEMPERATURE;
    end else if (n[13][0]) begin
      r.unit_code = UNIT_FAHRENHEIT; r.special_mode = MODE_TEMPERATURE;
    end

    if (n[9][1]) begin
      r.prefix_code = PREFIX_NANO;
    end else if (n[9][0]) begin
      r.prefix_code = PREFIX_MICRO;
    end else if (n[10][0]) begin
      r.prefix_code = PREFIX_MILLI;
    end else if (n[9][2]) begin
      r.prefix_code = PREFIX_KILO;
    end else if (n[10][2]) begin
      r.prefix_code = PREFIX_MEGA;
    end else begin
      r.prefix_code = PREFIX_NONE;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/lcd_segment_packet_decoder_unit.sv =====
`timescale 1ns / 1ps

// Seven-segment LCD multimeter frame decoder.
//
// The input stream (s_axis_*) carries one received meter byte per request. While
// hunting, bytes are dropped until one arrives whose upper nibble is all ones; that
// byte opens a 15-byte frame. The low nibbles of the first 14 bytes are held in a
// bank of nibble registers. When the fifteenth byte is taken, the stored nibbles are
// decoded in one pass and the reading is loaded into the output register, so the
// output stream (m_axis_*) shows it in the cycle after that byte. The block takes one
// byte every cycle unless a closing byte waits on the single output register.
//
// If the receiver stalls, the reading stays in the output register. Bytes that do not
// close a frame are still accepted; only the closing byte waits until the output
// register is free or is being emptied in the same cycle.
//
// Synchronous reset (rst, active high) returns the block to hunting for a start byte
// and empties the output register. The nibble bank is not cleared: every nibble that
// is decoded has been written earlier in the same frame.
module lcd_segment_packet_decoder_unit
  import lcdspd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] raw_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] overload, [1] negative, [5:2] digit_first, [9:6] digit_second,
  // [13:10] digit_third, [17:14] digit_fourth, [19:18] point_after,
  // [23:20] special_mode, [27:24] unit_code, [30:28] prefix_code, [31] zero
  output logic [31:0] m_axis_tdata
);

  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_BYTES - 1);

  frame_t             nibbles;
  logic [COUNT_W-1:0] byte_count;
  logic               in_frame;
  reading_t           reading;
  reading_t           decoded;

  logic in_accept;
  logic closing;
  logic out_free;

  // The closing byte is known from the counter alone, so ready never depends on data.
  assign closing       = in_frame && (byte_count == LAST_COUNT);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !closing || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign decoded = decode_frame(nibbles);

  // Frame tracking: a start-like byte inside a frame is just another frame byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      byte_count <= '0;
    end else if (in_accept) begin
      if (!in_frame) begin
        if (s_axis_tdata[7:4] == START_NIBBLE) begin
          in_frame   <= 1'b1;
          byte_count <= COUNT_W'(1);
        end
      end else if (closing) begin
        in_frame   <= 1'b0;
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + COUNT_W'(1);
      end
    end
  end

  // Nibble bank; the closing byte's nibble is not kept.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!in_frame) begin
        nibbles[0] <= s_axis_tdata[3:0];
      end else if (!closing) begin
        nibbles[byte_count] <= s_axis_tdata[3:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_accept && closing) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && closing) begin
      reading <= decoded;
    end
  end

  assign m_axis_tdata = {1'b0, reading.prefix_code, reading.unit_code, reading.special_mode,
                         reading.point_after, reading.digit_fourth, reading.digit_third,
                         reading.digit_second, reading.digit_first, reading.negative,
                         reading.overload};

  // A fresh reading only ever follows the frame's closing byte.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_accept && closing))
    else $error("reading appeared without a closing byte");

  // Taking the closing byte ends the frame and presents a reading.
  assert property (@(posedge clk) disable iff (rst)
    (in_accept && closing) |=> (!in_frame && m_axis_tvalid))
    else $error("closing byte did not end the frame");

  // While hunting the counter rests at zero.
  assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> (byte_count == '0))
    else $error("byte counter running outside a frame");

  // A stalled reading must never be overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(in_accept && closing))
    else $error("closing byte taken while output stalled");

endmodule
